FILE: rtl/sda_pkg.sv
// Shared types and constants for the scaled-decimal ALU.
// Operation and status codes, stage control struct and the power-of-ten helper.
package sda_pkg;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_SUB     = 3'd1;
   localparam logic [2:0] OP_MUL     = 3'd2;
   localparam logic [2:0] OP_DIV     = 3'd3;
   localparam logic [2:0] OP_MUL_INT = 3'd4;
   localparam logic [2:0] OP_DIV_INT = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_INT_ZERO = 2'd2;

   localparam int SCALE_STEPS = 32;

   typedef struct packed {
      logic              valid;
      logic [2:0]        op;
      logic signed [6:0] exp;
      logic [1:0]        status;
      logic [4:0]        zeros;
   } sda_ctl_type;

   // 10^n modulo 2^64, evaluated at elaboration only
   function automatic logic [63:0] pow10_f(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

FILE: rtl/sda_scale.sv
// Operand alignment: two register stages that scale the operand with fewer
// fractional digits by a power of ten. Depends on sda_pkg.
module sda_scale #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [2:0]          op,
   input  logic [31:0]         a_m,
   input  logic [4:0]          a_e,
   input  logic [31:0]         b_m,
   input  logic [4:0]          b_e,
   output sda_pkg::sda_ctl_type ctl_out,
   output logic [W-1:0]        am_out,
   output logic [W-1:0]        bm_out,
   output logic [W-1:0]        mag_out,
   output logic                bneg_out
);
   import sda_pkg::*;

   logic [W-1:0] pow_tab [SCALE_STEPS];

   for (genvar g = 0; g < SCALE_STEPS; g++) begin : g_pow
      localparam logic [63:0] P = pow10_f(g);
      assign pow_tab[g] = P[W-1:0];
   end

   logic signed [63:0] a_ext, b_ext;
   logic [W-1:0]       am_w, bm_w;
   logic signed [4:0]  ae, be;
   logic               lt, scale_a;
   logic signed [5:0]  diff;
   logic [4:0]         steps;
   logic signed [4:0]  c;
   logic signed [6:0]  exp_w;

   sda_ctl_type  ctl0_ff, ctl0_in;
   logic [W-1:0] x_ff, x_in, f_ff, f_in, y_ff, y_in, mag_ff, mag_in;
   logic         sa_ff, bneg_ff;
   sda_ctl_type  ctl1_ff;
   logic [W-1:0] am1_ff, bm1_ff, mag1_ff;
   logic         bneg1_ff;
   logic [2*W-1:0] prod;

   always_comb begin
      a_ext   = 64'($signed(a_m));
      b_ext   = 64'($signed(b_m));
      am_w    = a_ext[W-1:0];
      bm_w    = b_ext[W-1:0];
      ae      = $signed(a_e);
      be      = $signed(b_e);
      lt      = ae < be;
      diff    = lt ? (6'(be) - 6'(ae)) : (6'(ae) - 6'(be));
      c       = lt ? be : ae;
      scale_a = lt || (op > OP_DIV);
      steps   = (op > OP_DIV) ? 5'd0 : diff[4:0];
      unique case (op)
         OP_ADD, OP_SUB: exp_w = 7'(c);
         OP_MUL:         exp_w = 7'(c) + 7'(c);
         OP_MUL_INT, OP_DIV_INT: exp_w = 7'(ae);
         default:        exp_w = 7'sd0;
      endcase
      ctl0_in        = '0;
      ctl0_in.valid  = in_valid;
      ctl0_in.op     = op;
      ctl0_in.exp    = exp_w;
      ctl0_in.status = ST_OK;
      x_in   = scale_a ? am_w : bm_w;
      y_in   = scale_a ? bm_w : am_w;
      f_in   = pow_tab[steps];
      mag_in = bm_w[W-1] ? (W'(0) - bm_w) : bm_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
         ctl1_ff.valid <= 1'b0;
      end else begin
         ctl0_ff.valid <= ctl0_in.valid;
         ctl1_ff.valid <= ctl0_ff.valid;
      end
      ctl0_ff.op     <= ctl0_in.op;
      ctl0_ff.exp    <= ctl0_in.exp;
      ctl0_ff.status <= ctl0_in.status;
      ctl0_ff.zeros  <= ctl0_in.zeros;
      x_ff    <= x_in;
      y_ff    <= y_in;
      f_ff    <= f_in;
      mag_ff  <= mag_in;
      sa_ff   <= scale_a;
      bneg_ff <= bm_w[W-1];
      ctl1_ff.op     <= ctl0_ff.op;
      ctl1_ff.exp    <= ctl0_ff.exp;
      ctl1_ff.status <= ctl0_ff.status;
      ctl1_ff.zeros  <= ctl0_ff.zeros;
      am1_ff   <= sa_ff ? prod[W-1:0] : y_ff;
      bm1_ff   <= sa_ff ? y_ff : prod[W-1:0];
      mag1_ff  <= mag_ff;
      bneg1_ff <= bneg_ff;
   end

   assign prod     = (2*W)'(x_ff) * (2*W)'(f_ff);
   assign ctl_out  = ctl1_ff;
   assign am_out   = am1_ff;
   assign bm_out   = bm1_ff;
   assign mag_out  = mag1_ff;
   assign bneg_out = bneg1_ff;

endmodule

FILE: rtl/sda_strip.sv
// One trailing-zero strip stage: drop one decimal zero from the integer
// operand magnitude when it divides by ten. Depends on sda_pkg.
module sda_strip #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  sda_pkg::sda_ctl_type ctl_in,
   input  logic [W-1:0]        am_in,
   input  logic [W-1:0]        bm_in,
   input  logic [W-1:0]        mag_in,
   input  logic                bneg_in,
   output sda_pkg::sda_ctl_type ctl_out,
   output logic [W-1:0]        am_out,
   output logic [W-1:0]        bm_out,
   output logic [W-1:0]        mag_out,
   output logic                bneg_out
);
   import sda_pkg::*;

   localparam logic [W+4:0] TWO_P = (W+5)'(1) << (W+3);
   localparam logic [W+4:0] RECIP_FULL = (TWO_P + (W+5)'(9)) / (W+5)'(10);
   localparam logic [W-1:0] RECIP = RECIP_FULL[W-1:0];

   logic [2*W-1:0] prod;
   logic [W-1:0]   quot, rem;
   logic           take;
   sda_ctl_type    ctl_ff;
   logic [W-1:0]   am_ff, bm_ff, mag_ff;
   logic           bneg_ff;

   always_comb begin
      prod = (2*W)'(mag_in) * (2*W)'(RECIP);
      quot = W'(prod >> (W+3));
      rem  = mag_in - ((quot << 3) + (quot << 1));
      take = (ctl_in.op == OP_MUL_INT || ctl_in.op == OP_DIV_INT) &&
             (mag_in != '0) && (rem == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op     <= ctl_in.op;
      ctl_ff.exp    <= ctl_in.exp;
      ctl_ff.status <= ctl_in.status;
      ctl_ff.zeros  <= take ? ctl_in.zeros + 5'd1 : ctl_in.zeros;
      mag_ff  <= take ? quot : mag_in;
      am_ff   <= am_in;
      bm_ff   <= bm_in;
      bneg_ff <= bneg_in;
   end

   assign ctl_out  = ctl_ff;
   assign am_out   = am_ff;
   assign bm_out   = bm_ff;
   assign mag_out  = mag_ff;
   assign bneg_out = bneg_ff;

endmodule

FILE: rtl/sda_div_stage.sv
// One restoring-division step: one quotient bit per stage on magnitudes,
// with the non-division result carried alongside. Depends on sda_pkg.
module sda_div_stage #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  sda_pkg::sda_ctl_type ctl_in,
   input  logic                qneg_in,
   input  logic [W-1:0]        num_in,
   input  logic [W-1:0]        den_in,
   input  logic [W-1:0]        rem_in,
   input  logic [W-1:0]        quo_in,
   input  logic [W-1:0]        res_in,
   output sda_pkg::sda_ctl_type ctl_out,
   output logic                qneg_out,
   output logic [W-1:0]        num_out,
   output logic [W-1:0]        den_out,
   output logic [W-1:0]        rem_out,
   output logic [W-1:0]        quo_out,
   output logic [W-1:0]        res_out
);
   import sda_pkg::*;

   logic [W:0]   trial;
   logic         fits;
   sda_ctl_type  ctl_ff;
   logic         qneg_ff;
   logic [W-1:0] num_ff, den_ff, rem_ff, quo_ff, res_ff;

   always_comb begin
      trial = {rem_in, num_in[W-1]};
      fits  = trial >= {1'b0, den_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.op     <= ctl_in.op;
      ctl_ff.exp    <= ctl_in.exp;
      ctl_ff.status <= ctl_in.status;
      ctl_ff.zeros  <= ctl_in.zeros;
      qneg_ff <= qneg_in;
      num_ff  <= num_in << 1;
      den_ff  <= den_in;
      rem_ff  <= fits ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
      quo_ff  <= {quo_in[W-2:0], fits};
      res_ff  <= res_in;
   end

   assign ctl_out  = ctl_ff;
   assign qneg_out = qneg_ff;
   assign num_out  = num_ff;
   assign den_out  = den_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign res_out  = res_ff;

endmodule

FILE: rtl/scaled_decimal_alu.sv
// Scaled-decimal ALU, fully pipelined; one operation per cycle, never busy.
// Stages in order: operand alignment, zero strip, operand preparation, multiply,
// restoring divide and output register, the same path for every operation code.
// Throughput one item per cycle; the divider takes one quotient bit per stage.
// Synchronous reset clears all stage valid bits; no result appears until fed.
module scaled_decimal_alu #(
   parameter int MANT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_a_mantissa,
   input  logic [4:0]  req_a_exponent,
   input  logic [31:0] req_b_mantissa,
   input  logic [4:0]  req_b_exponent,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_mantissa,
   output logic [6:0]  rsp_result_exponent,
   output logic [1:0]  rsp_status
);
   import sda_pkg::*;

   localparam int W    = MANT_BITS;
   localparam int KMAX = (MANT_BITS * 30103) / 100000;

   sda_ctl_type  ctl_s  [KMAX+1];
   logic [W-1:0] am_s   [KMAX+1];
   logic [W-1:0] bm_s   [KMAX+1];
   logic [W-1:0] mag_s  [KMAX+1];
   logic         bneg_s [KMAX+1];

   assign busy = 1'b0;

   sda_scale #(.W(W)) u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .op       (req_operation),
      .a_m      (req_a_mantissa),
      .a_e      (req_a_exponent),
      .b_m      (req_b_mantissa),
      .b_e      (req_b_exponent),
      .ctl_out  (ctl_s[0]),
      .am_out   (am_s[0]),
      .bm_out   (bm_s[0]),
      .mag_out  (mag_s[0]),
      .bneg_out (bneg_s[0])
   );

   for (genvar k = 0; k < KMAX; k++) begin : g_strip
      sda_strip #(.W(W)) u_strip (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (ctl_s[k]),
         .am_in    (am_s[k]),
         .bm_in    (bm_s[k]),
         .mag_in   (mag_s[k]),
         .bneg_in  (bneg_s[k]),
         .ctl_out  (ctl_s[k+1]),
         .am_out   (am_s[k+1]),
         .bm_out   (bm_s[k+1]),
         .mag_out  (mag_s[k+1]),
         .bneg_out (bneg_s[k+1])
      );
   end

   // operand preparation
   sda_ctl_type  sc, pc_in, pc_ff;
   logic [W-1:0] sam, sbm, rest, divisor;
   logic [W-1:0] ma_in, mb_in, res_in, num_in, den_in;
   logic [W-1:0] ma_ff, mb_ff, pres_ff, pnum_ff, pden_ff;
   logic         qneg_in, pqneg_ff, zero;

   always_comb begin
      sc      = ctl_s[KMAX];
      sam     = am_s[KMAX];
      sbm     = bm_s[KMAX];
      rest    = bneg_s[KMAX] ? (W'(0) - mag_s[KMAX]) : mag_s[KMAX];
      zero    = sbm == '0;
      pc_in   = sc;
      ma_in   = sam;
      mb_in   = (sc.op == OP_MUL) ? sbm : rest;
      res_in  = '0;
      divisor = (sc.op == OP_DIV) ? sbm : rest;
      unique case (sc.op)
         OP_ADD: res_in = sam + sbm;
         OP_SUB: res_in = sam - sbm;
         OP_MUL_INT: pc_in.exp = sc.exp - 7'(sc.zeros);
         OP_DIV_INT: pc_in.exp = sc.exp + 7'(sc.zeros);
         default: res_in = '0;
      endcase
      if (zero && sc.op == OP_DIV) begin
         pc_in.status = ST_DIV_ZERO;
         pc_in.exp    = '0;
      end else if (zero && (sc.op == OP_MUL_INT || sc.op == OP_DIV_INT)) begin
         pc_in.status = ST_INT_ZERO;
         pc_in.exp    = '0;
      end
      num_in  = sam[W-1] ? (W'(0) - sam) : sam;
      den_in  = zero ? W'(1) : (divisor[W-1] ? (W'(0) - divisor) : divisor);
      qneg_in = sam[W-1] ^ divisor[W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff.valid <= 1'b0;
      end else begin
         pc_ff.valid <= pc_in.valid;
      end
      pc_ff.op     <= pc_in.op;
      pc_ff.exp    <= pc_in.exp;
      pc_ff.status <= pc_in.status;
      pc_ff.zeros  <= pc_in.zeros;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      pres_ff  <= res_in;
      pnum_ff  <= num_in;
      pden_ff  <= den_in;
      pqneg_ff <= qneg_in;
   end

   // multiply stage
   logic [2*W-1:0] prod;
   sda_ctl_type    dc   [W+1];
   logic           dqn  [W+1];
   logic [W-1:0]   dnum [W+1];
   logic [W-1:0]   dden [W+1];
   logic [W-1:0]   drem [W+1];
   logic [W-1:0]   dquo [W+1];
   logic [W-1:0]   dres [W+1];
   sda_ctl_type    mc_ff;
   logic           mqn_ff;
   logic [W-1:0]   mnum_ff, mden_ff, mres_ff;

   assign prod = (2*W)'(ma_ff) * (2*W)'(mb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff.valid <= 1'b0;
      end else begin
         mc_ff.valid <= pc_ff.valid;
      end
      mc_ff.op     <= pc_ff.op;
      mc_ff.exp    <= pc_ff.exp;
      mc_ff.status <= pc_ff.status;
      mc_ff.zeros  <= pc_ff.zeros;
      mqn_ff  <= pqneg_ff;
      mnum_ff <= pnum_ff;
      mden_ff <= pden_ff;
      mres_ff <= (pc_ff.op == OP_MUL || pc_ff.op == OP_MUL_INT) ? prod[W-1:0] : pres_ff;
   end

   assign dc[0]   = mc_ff;
   assign dqn[0]  = mqn_ff;
   assign dnum[0] = mnum_ff;
   assign dden[0] = mden_ff;
   assign drem[0] = '0;
   assign dquo[0] = '0;
   assign dres[0] = mres_ff;

   for (genvar i = 0; i < W; i++) begin : g_div
      sda_div_stage #(.W(W)) u_div (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (dc[i]),
         .qneg_in  (dqn[i]),
         .num_in   (dnum[i]),
         .den_in   (dden[i]),
         .rem_in   (drem[i]),
         .quo_in   (dquo[i]),
         .res_in   (dres[i]),
         .ctl_out  (dc[i+1]),
         .qneg_out (dqn[i+1]),
         .num_out  (dnum[i+1]),
         .den_out  (dden[i+1]),
         .rem_out  (drem[i+1]),
         .quo_out  (dquo[i+1]),
         .res_out  (dres[i+1])
      );
   end

   // result select and output register
   sda_ctl_type        fc;
   logic [W-1:0]       quot;
   logic signed [W-1:0] mant;
   logic signed [63:0] mant_ext;
   logic               valid_ff;
   logic [31:0]        mant_ff;
   logic [6:0]         exp_ff;
   logic [1:0]         status_ff;

   always_comb begin
      fc   = dc[W];
      quot = dqn[W] ? (W'(0) - dquo[W]) : dquo[W];
      mant = (fc.op == OP_DIV || fc.op == OP_DIV_INT) ? quot : dres[W];
      if (fc.status != ST_OK) begin
         mant = '0;
      end
      mant_ext = 64'(mant);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= fc.valid;
      end
      mant_ff   <= mant_ext[31:0];
      exp_ff    <= fc.exp;
      status_ff <= fc.status;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_result_mantissa = mant_ff;
   assign rsp_result_exponent = exp_ff;
   assign rsp_status          = status_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_mantissa == '0 &&
      rsp_result_exponent == '0)
      else $error("error status with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_DIV_ZERO ||
      rsp_status == ST_INT_ZERO)
      else $error("undefined status code");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      mc_ff.valid |=> dc[1].valid)
      else $error("divider lost an item");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      mc_ff.valid |-> mden_ff != '0)
      else $error("zero divisor reached divider");

endmodule
